// File: hw/rtl/ipv4_masked_header_rewrite_defines.svh
// Assertion macros for the IPv4 masked header rewrite block.
// Included by files that carry concurrent assertions; expects i_clk and i_rst_n.
`ifndef IPV4_MASKED_HEADER_REWRITE_DEFINES_SVH
`define IPV4_MASKED_HEADER_REWRITE_DEFINES_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define IMHR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle, checked outside reset.
`define IMHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/imhr_pkg.sv
// Shared types, codes and checksum functions of the IPv4 masked header rewrite.
// Used by every module of the block; depends on nothing.
`default_nettype none

package imhr_pkg;

    localparam logic [1:0]  KIND_TCP       = 2'd1;
    localparam logic [1:0]  KIND_UDP       = 2'd2;
    localparam logic [15:0] UDP_ZERO_SUBST = 16'hFFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_SRC  = 3'd0,
        CFG_KEY_DST  = 3'd1,
        CFG_KEY_TOS  = 3'd2,
        CFG_KEY_TTL  = 3'd3,
        CFG_MASK_SRC = 3'd4,
        CFG_MASK_DST = 3'd5,
        CFG_MASK_TOS = 3'd6,
        CFG_MASK_TTL = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        SEL_SRC = 1'b0,
        SEL_DST = 1'b1
    } t_addr_sel;

    typedef struct packed {
        logic [31:0] key_src;
        logic [31:0] key_dst;
        logic [7:0]  key_tos;
        logic [7:0]  key_ttl;
        logic [31:0] mask_src;
        logic [31:0] mask_dst;
        logic [7:0]  mask_tos;
        logic [7:0]  mask_ttl;
    } t_cfg;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [15:0] hc;
        logic [1:0]  kind;
        logic        present;
        logic [15:0] l4;
        logic        offl;
    } t_hdr;

    typedef struct packed {
        logic src;
        logic dst;
        logic tos;
        logic ttl;
    } t_apply;

    typedef struct packed {
        logic [31:0] old_src;
        logic [31:0] new_src;
        logic [31:0] old_dst;
        logic [31:0] new_dst;
        logic [7:0]  old_tos;
        logic [7:0]  new_tos;
        logic [7:0]  old_ttl;
        logic [7:0]  new_ttl;
        logic [15:0] hc;
        logic [1:0]  kind;
        logic        present;
        logic [15:0] l4;
        logic        offl;
        t_apply      apply;
    } t_work;

    // Replaces a 32-bit quantity in a 16-bit ones' complement sum.
    // With inv set the sum is stored inverted, as in a checksum field.
    function automatic logic [15:0] csum_replace(input logic [15:0] sum,
                                                 input logic [31:0] from,
                                                 input logic [31:0] to,
                                                 input logic        inv);
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] nf_hi;
        logic [15:0] nf_lo;
        logic [18:0] s;
        logic [16:0] a;
        logic [15:0] b;
        w0    = inv ? ~sum : sum;
        w1    = inv ? 16'hFFFF : 16'h0000;
        nf_hi = ~from[31:16];
        nf_lo = ~from[15:0];
        s = 19'(w0) + 19'(w1) + 19'(nf_hi) + 19'(nf_lo)
          + 19'(to[31:16]) + 19'(to[15:0]);
        a = 17'(s[15:0]) + 17'(s[18:16]);
        b = a[15:0] + 16'(a[16]);
        return inv ? ~b : b;
    endfunction

    // Direct header checksum update for a changed TOS byte.
    function automatic logic [15:0] tos_update(input logic [15:0] hc,
                                               input logic [7:0]  old_tos,
                                               input logic [7:0]  new_tos);
        logic [16:0] c;
        logic [15:0] c16;
        logic [16:0] d;
        c = 17'(hc) + 17'(old_tos);
        if (c >= 17'h0FFFF) begin
            c16 = c[15:0] + 16'd1;
        end else begin
            c16 = c[15:0];
        end
        d = {1'b0, c16} - 17'(new_tos);
        return d[15:0] - 16'(d[16]);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imhr_merge.sv
// First pipeline stage: merges key bits into the header fields under the masks.
// Depends on imhr_pkg.
`default_nettype none

module imhr_merge (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire imhr_pkg::t_hdr i_hdr,
    input  wire imhr_pkg::t_cfg i_cfg,
    output logic                o_valid,
    output imhr_pkg::t_work     o_work
);

    logic             r_valid;
    imhr_pkg::t_work  r_work;
    imhr_pkg::t_work  n_work;

    always_comb begin
        n_work.apply.src = (i_cfg.mask_src != '0);
        n_work.apply.dst = (i_cfg.mask_dst != '0);
        n_work.apply.tos = (i_cfg.mask_tos != '0);
        n_work.apply.ttl = (i_cfg.mask_ttl != '0);
        n_work.old_src   = i_hdr.src;
        n_work.old_dst   = i_hdr.dst;
        n_work.old_tos   = i_hdr.tos;
        n_work.old_ttl   = i_hdr.ttl;
        n_work.new_src   = n_work.apply.src
                         ? (i_cfg.key_src | (i_hdr.src & ~i_cfg.mask_src)) : i_hdr.src;
        n_work.new_dst   = n_work.apply.dst
                         ? (i_cfg.key_dst | (i_hdr.dst & ~i_cfg.mask_dst)) : i_hdr.dst;
        n_work.new_tos   = n_work.apply.tos
                         ? (i_cfg.key_tos | (i_hdr.tos & ~i_cfg.mask_tos)) : i_hdr.tos;
        n_work.new_ttl   = n_work.apply.ttl
                         ? (i_cfg.key_ttl | (i_hdr.ttl & ~i_cfg.mask_ttl)) : i_hdr.ttl;
        n_work.hc        = i_hdr.hc;
        n_work.kind      = i_hdr.kind;
        n_work.present   = i_hdr.present;
        n_work.l4        = i_hdr.l4;
        n_work.offl      = i_hdr.offl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

// File: hw/rtl/imhr_addr_upd.sv
// Pipeline stage that folds one address rewrite into the header and L4 checksums.
// Used once for the source and once for the destination; depends on imhr_pkg.
`default_nettype none

module imhr_addr_upd (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire imhr_pkg::t_addr_sel i_sel,
    input  wire logic                i_valid,
    input  wire imhr_pkg::t_work     i_work,
    output logic                     o_valid,
    output imhr_pkg::t_work          o_work
);

    logic             r_valid;
    imhr_pkg::t_work  r_work;
    imhr_pkg::t_work  n_work;
    logic [31:0]      from_addr;
    logic [31:0]      to_addr;
    logic             apply;
    logic [15:0]      l4_upd;

    always_comb begin
        from_addr = (i_sel == imhr_pkg::SEL_DST) ? i_work.old_dst : i_work.old_src;
        to_addr   = (i_sel == imhr_pkg::SEL_DST) ? i_work.new_dst : i_work.new_src;
        apply     = (i_sel == imhr_pkg::SEL_DST) ? i_work.apply.dst : i_work.apply.src;
        l4_upd    = imhr_pkg::csum_replace(i_work.l4, from_addr, to_addr, !i_work.offl);

        n_work = i_work;
        if (apply) begin
            n_work.hc = imhr_pkg::csum_replace(i_work.hc, from_addr, to_addr, 1'b1);
            if (i_work.present && i_work.kind == imhr_pkg::KIND_TCP) begin
                n_work.l4 = l4_upd;
            end else if (i_work.present && i_work.kind == imhr_pkg::KIND_UDP
                         && (i_work.l4 != '0 || i_work.offl)) begin
                n_work.l4 = (l4_upd == '0) ? imhr_pkg::UDP_ZERO_SUBST : l4_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

// File: hw/rtl/imhr_tos_ttl.sv
// Last two pipeline stages: header checksum update for TOS, then for TTL.
// The second stage holds the result registers; depends on imhr_pkg.
`default_nettype none

module imhr_tos_ttl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire imhr_pkg::t_work i_work,
    output logic                o_valid,
    output imhr_pkg::t_hdr      o_hdr
);

    logic             r_tos_valid;
    imhr_pkg::t_work  r_tos_work;
    imhr_pkg::t_work  n_tos_work;
    logic             r_out_valid;
    imhr_pkg::t_hdr   r_out;
    imhr_pkg::t_hdr   n_out;

    always_comb begin
        n_tos_work = i_work;
        if (i_work.apply.tos) begin
            n_tos_work.hc = imhr_pkg::tos_update(i_work.hc, i_work.old_tos, i_work.new_tos);
        end
    end

    always_comb begin
        n_out.src     = r_tos_work.new_src;
        n_out.dst     = r_tos_work.new_dst;
        n_out.tos     = r_tos_work.new_tos;
        n_out.ttl     = r_tos_work.new_ttl;
        n_out.hc      = r_tos_work.hc;
        n_out.kind    = r_tos_work.kind;
        n_out.present = r_tos_work.present;
        n_out.l4      = r_tos_work.l4;
        n_out.offl    = r_tos_work.offl;
        if (r_tos_work.apply.ttl) begin
            n_out.hc = imhr_pkg::csum_replace(r_tos_work.hc,
                                              {16'h0000, r_tos_work.old_ttl, 8'h00},
                                              {16'h0000, r_tos_work.new_ttl, 8'h00},
                                              1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tos_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tos_valid <= i_valid;
            r_out_valid <= r_tos_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos_work <= n_tos_work;
        r_out      <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_hdr   = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/ipv4_masked_header_rewrite.sv
// Top level of the IPv4 masked header rewrite with incremental checksum update.
// Instantiates imhr_merge, imhr_addr_upd and imhr_tos_ttl; depends on imhr_pkg.
//
// Usage: an item (the address, TOS, TTL and checksum fields of one IPv4 header
// plus its transport kind and checksum) is accepted at each rising edge with
// start high and busy low. busy stays low, so an item can be offered in every
// cycle. Each item yields exactly one result, shown on the o_new_* ports for
// one cycle with o_strobe high; the receiver cannot stall, and none is needed.
// Throughput is one item per cycle, through a five-stage pipeline: key merge,
// source address checksum update, destination address checksum update, TOS
// update, TTL update with the result registers.
// Key and mask registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must write them only while no item is in flight,
// as the block itself does not enforce it.
// Reset clears all key and mask registers and drops every item in the pipeline.
`default_nettype none

module ipv4_masked_header_rewrite (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_cfg_we,
    input  wire logic [imhr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [imhr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [31:0]                       i_old_source_address,
    input  wire logic [31:0]                       i_old_dest_address,
    input  wire logic [7:0]                        i_old_type_of_service,
    input  wire logic [7:0]                        i_old_time_to_live,
    input  wire logic [15:0]                       i_old_header_checksum,
    input  wire logic [1:0]                        i_l4_kind,
    input  wire logic                              i_l4_header_present,
    input  wire logic [15:0]                       i_old_l4_checksum,
    input  wire logic                              i_l4_checksum_offloaded,
    output logic                                   o_strobe,
    output logic [31:0]                            o_new_source_address,
    output logic [31:0]                            o_new_dest_address,
    output logic [7:0]                             o_new_type_of_service,
    output logic [7:0]                             o_new_time_to_live,
    output logic [15:0]                            o_new_header_checksum,
    output logic [15:0]                            o_new_l4_checksum
);

    imhr_pkg::t_cfg   r_cfg;
    imhr_pkg::t_hdr   in_hdr;
    imhr_pkg::t_hdr   out_hdr;
    imhr_pkg::t_work  merge_work;
    imhr_pkg::t_work  src_work;
    imhr_pkg::t_work  dst_work;
    logic             in_valid;
    logic             merge_valid;
    logic             src_valid;
    logic             dst_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (imhr_pkg::t_cfg_idx'(i_cfg_index))
                imhr_pkg::CFG_KEY_SRC:  r_cfg.key_src  <= i_cfg_data;
                imhr_pkg::CFG_KEY_DST:  r_cfg.key_dst  <= i_cfg_data;
                imhr_pkg::CFG_KEY_TOS:  r_cfg.key_tos  <= i_cfg_data[7:0];
                imhr_pkg::CFG_KEY_TTL:  r_cfg.key_ttl  <= i_cfg_data[7:0];
                imhr_pkg::CFG_MASK_SRC: r_cfg.mask_src <= i_cfg_data;
                imhr_pkg::CFG_MASK_DST: r_cfg.mask_dst <= i_cfg_data;
                imhr_pkg::CFG_MASK_TOS: r_cfg.mask_tos <= i_cfg_data[7:0];
                imhr_pkg::CFG_MASK_TTL: r_cfg.mask_ttl <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_comb begin
        in_hdr.src     = i_old_source_address;
        in_hdr.dst     = i_old_dest_address;
        in_hdr.tos     = i_old_type_of_service;
        in_hdr.ttl     = i_old_time_to_live;
        in_hdr.hc      = i_old_header_checksum;
        in_hdr.kind    = i_l4_kind;
        in_hdr.present = i_l4_header_present;
        in_hdr.l4      = i_old_l4_checksum;
        in_hdr.offl    = i_l4_checksum_offloaded;
    end

    imhr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_hdr   (in_hdr),
        .i_cfg   (r_cfg),
        .o_valid (merge_valid),
        .o_work  (merge_work)
    );

    imhr_addr_upd u_src_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (imhr_pkg::SEL_SRC),
        .i_valid (merge_valid),
        .i_work  (merge_work),
        .o_valid (src_valid),
        .o_work  (src_work)
    );

    imhr_addr_upd u_dst_upd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (imhr_pkg::SEL_DST),
        .i_valid (src_valid),
        .i_work  (src_work),
        .o_valid (dst_valid),
        .o_work  (dst_work)
    );

    imhr_tos_ttl u_tos_ttl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dst_valid),
        .i_work  (dst_work),
        .o_valid (o_strobe),
        .o_hdr   (out_hdr)
    );

    assign o_new_source_address  = out_hdr.src;
    assign o_new_dest_address    = out_hdr.dst;
    assign o_new_type_of_service = out_hdr.tos;
    assign o_new_time_to_live    = out_hdr.ttl;
    assign o_new_header_checksum = out_hdr.hc;
    assign o_new_l4_checksum     = out_hdr.l4;

`include "ipv4_masked_header_rewrite_defines.svh"

    `IMHR_ASSERT_IMPL(a_strobe_from_start, o_strobe, $past(start, 5), "result without an item")
    `IMHR_ASSERT_IMPL(a_no_mask_passthru, o_strobe && $past(r_cfg.mask_src == '0 && r_cfg.mask_dst == '0 && r_cfg.mask_tos == '0 && r_cfg.mask_ttl == '0, 5), o_new_header_checksum == $past(i_old_header_checksum, 5) && o_new_l4_checksum == $past(i_old_l4_checksum, 5), "checksums changed without a rewrite")
    `IMHR_ASSERT_IMPL(a_udp_zero_kept, o_strobe && o_new_l4_checksum == '0 && $past(i_l4_header_present && i_l4_kind == imhr_pkg::KIND_UDP, 5), $past(i_old_l4_checksum == '0, 5), "zero UDP checksum produced")

endmodule

`default_nettype wire

// File: verif/ipv4_rewrite_monitor.sv
`timescale 1ns / 100ps
// Checker for the IPv4 masked header rewrite: tracks key and mask writes,
// predicts each header rewrite and compares every result. Depends on imhr_pkg.
module ipv4_rewrite_monitor
    import imhr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]           i_old_source_address,
    input  logic [31:0]           i_old_dest_address,
    input  logic [7:0]            i_old_type_of_service,
    input  logic [7:0]            i_old_time_to_live,
    input  logic [15:0]           i_old_header_checksum,
    input  logic [1:0]            i_l4_kind,
    input  logic                  i_l4_header_present,
    input  logic [15:0]           i_old_l4_checksum,
    input  logic                  i_l4_checksum_offloaded,
    input  logic                  i_strobe,
    input  logic [31:0]           i_new_source_address,
    input  logic [31:0]           i_new_dest_address,
    input  logic [7:0]            i_new_type_of_service,
    input  logic [7:0]            i_new_time_to_live,
    input  logic [15:0]           i_new_header_checksum,
    input  logic [15:0]           i_new_l4_checksum,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [15:0] hc;
        logic [15:0] l4;
    } t_rewritten;

    t_cfg       rewrite_cfg;
    t_rewritten expected_headers[$];
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [15:0] ones_fold(input logic [63:0] s);
        logic [63:0] v;
        v = s;
        while (v[63:16] != 48'd0) begin
            v = {48'd0, v[15:0]} + {16'd0, v[63:16]};
        end
        return v[15:0];
    endfunction

    // Incremental update of a checksum field stored inverted.
    function automatic logic [15:0] csum_swap_inv(input logic [15:0] sum,
                                                  input logic [31:0] from,
                                                  input logic [31:0] to);
        logic [63:0] t;
        t = {32'd0, 16'hFFFF, ~sum} + {32'd0, ~from} + {32'd0, to};
        return ~ones_fold(t);
    endfunction

    // Incremental update of a plain pseudo-header sum.
    function automatic logic [15:0] csum_swap_plain(input logic [15:0] sum,
                                                    input logic [31:0] from,
                                                    input logic [31:0] to);
        logic [63:0] t;
        t = {48'd0, sum} + {32'd0, ~from} + {32'd0, to};
        return ones_fold(t);
    endfunction

    function automatic logic [15:0] tos_csum_adjust(input logic [15:0] hc,
                                                    input logic [7:0]  old_tos,
                                                    input logic [7:0]  new_tos);
        logic [31:0] c;
        c = {16'd0, hc} + {24'd0, old_tos};
        if (((c + 32'd1) >> 16) != 32'd0) begin
            c = (c + 32'd1) & 32'h0000FFFF;
        end
        c = c - {24'd0, new_tos};
        c = c + (c >> 16);
        return c[15:0];
    endfunction

    function automatic void address_csum_update(input logic [31:0]  from,
                                                input logic [31:0]  to,
                                                input t_hdr         h,
                                                inout logic [15:0]  hc,
                                                inout logic [15:0]  l4);
        if (h.present && h.kind == KIND_TCP) begin
            l4 = h.offl ? csum_swap_plain(l4, from, to) : csum_swap_inv(l4, from, to);
        end else if (h.present && h.kind == KIND_UDP && (l4 != 16'd0 || h.offl)) begin
            l4 = h.offl ? csum_swap_plain(l4, from, to) : csum_swap_inv(l4, from, to);
            if (l4 == 16'd0) begin
                l4 = UDP_ZERO_SUBST;
            end
        end
        hc = csum_swap_inv(hc, from, to);
    endfunction

    function automatic t_rewritten rewrite_header(input t_hdr h);
        t_rewritten r;
        logic [31:0] addr;
        logic [7:0]  octet;
        logic [15:0] hc;
        logic [15:0] l4;
        r  = '{src: h.src, dst: h.dst, tos: h.tos, ttl: h.ttl, hc: h.hc, l4: h.l4};
        hc = h.hc;
        l4 = h.l4;
        if (rewrite_cfg.mask_src != 32'd0) begin
            addr = rewrite_cfg.key_src | (h.src & ~rewrite_cfg.mask_src);
            address_csum_update(h.src, addr, h, hc, l4);
            r.src = addr;
        end
        if (rewrite_cfg.mask_dst != 32'd0) begin
            addr = rewrite_cfg.key_dst | (h.dst & ~rewrite_cfg.mask_dst);
            address_csum_update(h.dst, addr, h, hc, l4);
            r.dst = addr;
        end
        if (rewrite_cfg.mask_tos != 8'd0) begin
            octet = rewrite_cfg.key_tos | (h.tos & ~rewrite_cfg.mask_tos);
            hc    = tos_csum_adjust(hc, h.tos, octet);
            r.tos = octet;
        end
        if (rewrite_cfg.mask_ttl != 8'd0) begin
            octet = rewrite_cfg.key_ttl | (h.ttl & ~rewrite_cfg.mask_ttl);
            hc    = csum_swap_inv(hc, {16'd0, h.ttl, 8'd0}, {16'd0, octet, 8'd0});
            r.ttl = octet;
        end
        r.hc = hc;
        r.l4 = l4;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_hdr       h;
        t_rewritten want;
        if (!i_rst_n) begin
            rewrite_cfg = '0;
            expected_headers.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_SRC:  rewrite_cfg.key_src  = i_cfg_data;
                    CFG_KEY_DST:  rewrite_cfg.key_dst  = i_cfg_data;
                    CFG_KEY_TOS:  rewrite_cfg.key_tos  = i_cfg_data[7:0];
                    CFG_KEY_TTL:  rewrite_cfg.key_ttl  = i_cfg_data[7:0];
                    CFG_MASK_SRC: rewrite_cfg.mask_src = i_cfg_data;
                    CFG_MASK_DST: rewrite_cfg.mask_dst = i_cfg_data;
                    CFG_MASK_TOS: rewrite_cfg.mask_tos = i_cfg_data[7:0];
                    CFG_MASK_TTL: rewrite_cfg.mask_ttl = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (expected_headers.size() == 0) begin
                    $display("%0t: result with no item outstanding, expected none, actual %h",
                             $time, i_new_source_address);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = expected_headers.pop_front();
                    check_field("source address", want.src, i_new_source_address);
                    check_field("dest address", want.dst, i_new_dest_address);
                    check_field("type of service", {24'd0, want.tos},
                                {24'd0, i_new_type_of_service});
                    check_field("time to live", {24'd0, want.ttl}, {24'd0, i_new_time_to_live});
                    check_field("header checksum", {16'd0, want.hc},
                                {16'd0, i_new_header_checksum});
                    check_field("l4 checksum", {16'd0, want.l4}, {16'd0, i_new_l4_checksum});
                end
            end
            if (i_start && !i_busy) begin
                h = '{src: i_old_source_address, dst: i_old_dest_address,
                      tos: i_old_type_of_service, ttl: i_old_time_to_live,
                      hc: i_old_header_checksum, kind: i_l4_kind,
                      present: i_l4_header_present, l4: i_old_l4_checksum,
                      offl: i_l4_checksum_offloaded};
                expected_headers.push_back(rewrite_header(h));
            end
        end
        o_outstanding <= expected_headers.size();
    end

endmodule

// File: verif/tb_ipv4_masked_header_rewrite.sv
`timescale 1ns / 100ps
// Testbench top for the IPv4 masked header rewrite: resets the block, programs
// keys and masks, drives header items and gives the verdict from ipv4_rewrite_monitor.
module tb_ipv4_masked_header_rewrite;
    import imhr_pkg::*;

    localparam int         LATENCY         = 5;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         ITEMS_PER_PHASE = 53;
    localparam logic [1:0] KIND_OTHER      = 2'd0;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic [31:0]           i_old_source_address;
    logic [31:0]           i_old_dest_address;
    logic [7:0]            i_old_type_of_service;
    logic [7:0]            i_old_time_to_live;
    logic [15:0]           i_old_header_checksum;
    logic [1:0]            i_l4_kind;
    logic                  i_l4_header_present;
    logic [15:0]           i_old_l4_checksum;
    logic                  i_l4_checksum_offloaded;
    logic                  o_strobe;
    logic [31:0]           o_new_source_address;
    logic [31:0]           o_new_dest_address;
    logic [7:0]            o_new_type_of_service;
    logic [7:0]            o_new_time_to_live;
    logic [15:0]           o_new_header_checksum;
    logic [15:0]           o_new_l4_checksum;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          idle_pct = 9;
    logic [31:0] cur_key_src;
    logic [31:0] cur_key_dst;
    logic [7:0]  cur_key_tos;
    logic [7:0]  cur_key_ttl;

    always #5 i_clk = ~i_clk;

    ipv4_masked_header_rewrite dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .start                   (start),
        .busy                    (busy),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_old_source_address    (i_old_source_address),
        .i_old_dest_address      (i_old_dest_address),
        .i_old_type_of_service   (i_old_type_of_service),
        .i_old_time_to_live      (i_old_time_to_live),
        .i_old_header_checksum   (i_old_header_checksum),
        .i_l4_kind               (i_l4_kind),
        .i_l4_header_present     (i_l4_header_present),
        .i_old_l4_checksum       (i_old_l4_checksum),
        .i_l4_checksum_offloaded (i_l4_checksum_offloaded),
        .o_strobe                (o_strobe),
        .o_new_source_address    (o_new_source_address),
        .o_new_dest_address      (o_new_dest_address),
        .o_new_type_of_service   (o_new_type_of_service),
        .o_new_time_to_live      (o_new_time_to_live),
        .o_new_header_checksum   (o_new_header_checksum),
        .o_new_l4_checksum       (o_new_l4_checksum)
    );

    ipv4_rewrite_monitor u_monitor (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (start),
        .i_busy                  (busy),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_old_source_address    (i_old_source_address),
        .i_old_dest_address      (i_old_dest_address),
        .i_old_type_of_service   (i_old_type_of_service),
        .i_old_time_to_live      (i_old_time_to_live),
        .i_old_header_checksum   (i_old_header_checksum),
        .i_l4_kind               (i_l4_kind),
        .i_l4_header_present     (i_l4_header_present),
        .i_old_l4_checksum       (i_old_l4_checksum),
        .i_l4_checksum_offloaded (i_l4_checksum_offloaded),
        .i_strobe                (o_strobe),
        .i_new_source_address    (o_new_source_address),
        .i_new_dest_address      (o_new_dest_address),
        .i_new_type_of_service   (o_new_type_of_service),
        .i_new_time_to_live      (o_new_time_to_live),
        .i_new_header_checksum   (o_new_header_checksum),
        .i_new_l4_checksum       (o_new_l4_checksum),
        .o_mismatches            (mismatches),
        .o_outstanding           (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL ipv4_masked_header_rewrite");
            $finish;
        end
    end

    task automatic send_header(input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] tos, input logic [7:0] ttl,
                               input logic [15:0] hc, input logic [1:0] kind,
                               input logic present, input logic [15:0] l4,
                               input logic offl);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start                   <= 1'b1;
        i_old_source_address    <= src;
        i_old_dest_address      <= dst;
        i_old_type_of_service   <= tos;
        i_old_time_to_live      <= ttl;
        i_old_header_checksum   <= hc;
        i_l4_kind               <= kind;
        i_l4_header_present     <= present;
        i_old_l4_checksum       <= l4;
        i_l4_checksum_offloaded <= offl;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // The byte-wide registers get random upper data bits, which must be dropped.
    task automatic program_rewrite(input logic [31:0] k_src, input logic [31:0] k_dst,
                                   input logic [7:0] k_tos, input logic [7:0] k_ttl,
                                   input logic [31:0] m_src, input logic [31:0] m_dst,
                                   input logic [7:0] m_tos, input logic [7:0] m_ttl);
        write_reg(CFG_KEY_SRC, k_src);
        write_reg(CFG_KEY_DST, k_dst);
        write_reg(CFG_KEY_TOS, {24'($urandom), k_tos});
        write_reg(CFG_KEY_TTL, {24'($urandom), k_ttl});
        write_reg(CFG_MASK_SRC, m_src);
        write_reg(CFG_MASK_DST, m_dst);
        write_reg(CFG_MASK_TOS, {24'($urandom), m_tos});
        write_reg(CFG_MASK_TTL, {24'($urandom), m_ttl});
        i_cfg_we    <= 1'b0;
        cur_key_src = k_src;
        cur_key_dst = k_dst;
        cur_key_tos = k_tos;
        cur_key_ttl = k_ttl;
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_mask(input int width);
        logic [31:0] full;
        full = (width == 32) ? 32'hFFFFFFFF : 32'h000000FF;
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return full;
            2:       return $urandom & full;
            3:       return 32'd1 << $urandom_range(width - 1);
            default: return (full << $urandom_range(width - 1)) & full;
        endcase
    endfunction

    function automatic logic [31:0] pick_key(input logic [31:0] mask, input int width);
        logic [31:0] full;
        full = (width == 32) ? 32'hFFFFFFFF : 32'h000000FF;
        return (($urandom_range(4) == 0) ? $urandom : ($urandom & mask)) & full;
    endfunction

    task automatic random_setup();
        logic [31:0] m_src;
        logic [31:0] m_dst;
        logic [31:0] m_tos;
        logic [31:0] m_ttl;
        m_src = pick_mask(32);
        m_dst = pick_mask(32);
        m_tos = pick_mask(8);
        m_ttl = pick_mask(8);
        program_rewrite(pick_key(m_src, 32), pick_key(m_dst, 32),
                        8'(pick_key(m_tos, 8)), 8'(pick_key(m_ttl, 8)),
                        m_src, m_dst, 8'(m_tos), 8'(m_ttl));
    endtask

    task automatic random_header();
        logic [1:0]  kind;
        logic [15:0] hc;
        logic [15:0] l4;
        int          pick;
        pick = $urandom_range(9);
        kind = (pick < 4) ? KIND_TCP : (pick < 8) ? KIND_UDP :
               (pick == 8) ? KIND_OTHER : KIND_UNUSED;
        case ($urandom_range(9))
            0:       hc = 16'hFFFF;
            1:       hc = 16'h0000;
            default: hc = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1:    l4 = 16'h0000;
            2:       l4 = 16'hFFFF;
            default: l4 = 16'($urandom);
        endcase
        send_header(($urandom_range(9) == 0) ? cur_key_src : $urandom,
                    ($urandom_range(9) == 0) ? cur_key_dst : $urandom,
                    ($urandom_range(9) == 0) ? cur_key_tos : 8'($urandom),
                    ($urandom_range(9) == 0) ? cur_key_ttl : 8'($urandom),
                    hc, kind, $urandom_range(9) != 0, l4, $urandom_range(3) == 0);
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        start                   <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_index             <= CFG_KEY_SRC;
        i_cfg_data              <= '0;
        i_old_source_address    <= '0;
        i_old_dest_address      <= '0;
        i_old_type_of_service   <= '0;
        i_old_time_to_live      <= '0;
        i_old_header_checksum   <= '0;
        i_l4_kind               <= KIND_OTHER;
        i_l4_header_present     <= 1'b0;
        i_old_l4_checksum       <= '0;
        i_l4_checksum_offloaded <= 1'b0;
        cur_key_src = '0;
        cur_key_dst = '0;
        cur_key_tos = '0;
        cur_key_ttl = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset masks every header passes through unchanged.
        send_header(32'h0, 32'h0, 8'h00, 8'h00, 16'h0000, KIND_OTHER, 1'b0, 16'h0000, 1'b0);
        send_header(32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 16'hFFFF, KIND_UNUSED, 1'b1,
                    16'hFFFF, 1'b1);
        send_header($urandom, $urandom, 8'h10, 8'h40, 16'h1234, KIND_TCP, 1'b1, 16'hABCD, 1'b0);
        wait_for_drain();

        program_rewrite(32'h0, 32'hFFFFFFFF, 8'hFF, 8'h00,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF);
        send_header(32'hFFFFFFFF, 32'h0, 8'h00, 8'hFF, 16'hB1E6, KIND_TCP, 1'b1, 16'h1C46, 1'b0);
        send_header(32'h12345678, 32'h87654321, 8'h5A, 8'h80, 16'h0000, KIND_TCP, 1'b1,
                    16'h0000, 1'b1);
        send_header($urandom, $urandom, 8'h00, 8'h01, 16'($urandom), KIND_UDP, 1'b1,
                    16'h0000, 1'b0);
        send_header(32'hFFFFFFFF, 32'hFFFFFFFF, 8'h3C, 8'h7F, 16'($urandom), KIND_UDP, 1'b1,
                    16'h0000, 1'b1);
        send_header($urandom, $urandom, 8'hA5, 8'h02, 16'($urandom), KIND_UDP, 1'b1,
                    16'h8001, 1'b0);
        send_header($urandom, $urandom, 8'h11, 8'h22, 16'($urandom), KIND_OTHER, 1'b1,
                    16'($urandom), 1'b0);
        send_header($urandom, $urandom, 8'h33, 8'h44, 16'($urandom), KIND_UNUSED, 1'b1,
                    16'($urandom), 1'b1);
        send_header($urandom, $urandom, 8'h55, 8'h66, 16'($urandom), KIND_TCP, 1'b0,
                    16'($urandom), 1'b0);
        send_header($urandom, $urandom, 8'h77, 8'h88, 16'($urandom), KIND_UDP, 1'b0,
                    16'($urandom), 1'b1);
        wait_for_drain();

        // Rewrites to the value already present.
        program_rewrite(32'h0A000001, 32'hC0A80101, 8'hB8, 8'h40,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF);
        send_header(32'h0A000001, 32'hC0A80101, 8'hB8, 8'h40, 16'hFFFF, KIND_UDP, 1'b1,
                    16'hFFFF, 1'b0);
        send_header(32'h0A000001, 32'hC0A80101, 8'hB8, 8'h40, 16'h0000, KIND_TCP, 1'b1,
                    16'hFFFF, 1'b0);
        send_header(32'h0A000001, 32'hC0A80101, 8'hB8, 8'h40, 16'h7FFF, KIND_TCP, 1'b1,
                    16'h0000, 1'b1);
        wait_for_drain();

        program_rewrite(32'h000000AA, 32'h0, 8'h01, 8'h00, 32'h000000FF, 32'h0, 8'h01, 8'h00);
        send_header($urandom, $urandom, 8'hFE, 8'h09, 16'($urandom), KIND_TCP, 1'b1,
                    16'($urandom), 1'b0);
        send_header($urandom, $urandom, 8'h00, 8'hF0, 16'($urandom), KIND_UDP, 1'b1,
                    16'($urandom), 1'b1);
        send_header($urandom, $urandom, 8'hFF, 8'h00, 16'hFFFF, KIND_UDP, 1'b1,
                    16'h0000, 1'b0);
        wait_for_drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_pct = (phase == 4 || phase == 5) ? 0 : 9;
            random_setup();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_header();
            end
            wait_for_drain();
        end

        if (mismatches == 0) begin
            $display("PASS ipv4_masked_header_rewrite");
        end else begin
            $display("FAIL ipv4_masked_header_rewrite");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/imhr_pkg.sv
hw/rtl/imhr_merge.sv
hw/rtl/imhr_addr_upd.sv
hw/rtl/imhr_tos_ttl.sv
hw/rtl/ipv4_masked_header_rewrite.sv
verif/ipv4_rewrite_monitor.sv
verif/tb_ipv4_masked_header_rewrite.sv
